// File: hw/rtl/ppsp_pkg.sv
// shared types and constants for the p6 stream parser
package ppsp_pkg;

  localparam int DIM_W  = 13;
  localparam int BYTE_W = 8;
  localparam int NORM_W = 16;
  localparam int DIV_STEPS = 16;
  localparam int DIV_CNT_W = 4;

  // result kinds
  localparam logic [1:0] KIND_SAMPLE = 2'd0;
  localparam logic [1:0] KIND_HEADER = 2'd1;
  localparam logic [1:0] KIND_ERROR  = 2'd2;

  // error codes
  localparam logic [2:0] ERR_BAD_MAGIC = 3'd0;
  localparam logic [2:0] ERR_NO_WIDTH  = 3'd1;
  localparam logic [2:0] ERR_NO_HEIGHT = 3'd2;
  localparam logic [2:0] ERR_NO_MAX    = 3'd3;
  localparam logic [2:0] ERR_BAD_MAX   = 3'd4;
  localparam logic [2:0] ERR_NO_SEP    = 3'd5;
  localparam logic [2:0] ERR_SHORT     = 3'd6;
  localparam logic [2:0] ERR_TOO_LARGE = 3'd7;

  // characters
  localparam logic [7:0] CH_P     = 8'h50;
  localparam logic [7:0] CH_SIX   = 8'h36;
  localparam logic [7:0] CH_HASH  = 8'h23;
  localparam logic [7:0] CH_CR    = 8'h0D;
  localparam logic [7:0] CH_LF    = 8'h0A;
  localparam logic [7:0] CH_TAB   = 8'h09;
  localparam logic [7:0] CH_SPACE = 8'h20;
  localparam logic [7:0] CH_ZERO  = 8'h30;
  localparam logic [7:0] CH_NINE  = 8'h39;

  localparam logic [7:0] MAXVAL_LIMIT = 8'd255;

  typedef enum logic [3:0] {
    PH_MAGIC_P = 4'd0,
    PH_MAGIC_6 = 4'd1,
    PH_SKIP_W  = 4'd2,
    PH_WIDTH   = 4'd3,
    PH_SKIP_H  = 4'd4,
    PH_HEIGHT  = 4'd5,
    PH_SKIP_M  = 4'd6,
    PH_MAX     = 4'd7,
    PH_DATA    = 4'd8,
    PH_IDLE    = 4'd9
  } phase_t;

  typedef enum logic [1:0] {
    SEQ_IN    = 2'd0,
    SEQ_PARSE = 2'd1,
    SEQ_DIV   = 2'd2,
    SEQ_EMIT  = 2'd3
  } seq_t;

  typedef struct packed {
    logic                 has;
    logic [1:0]           kind;
    logic [2:0]           err;
    logic [BYTE_W-1:0]    raw;
    logic [1:0]           chan;
    logic                 done;
    logic [DIM_W-1:0]     width;
    logic [DIM_W-1:0]     height;
    logic [BYTE_W-1:0]    maxv;
  } res_t;

  typedef struct packed {
    logic busy;
    logic done;
  } div_stat_t;

endpackage

// File: hw/rtl/ppsp_div.sv
// restoring radix-2 divider, one quotient bit per cycle
module ppsp_div (
  input  logic                         clk,
  input  logic                         rst_n,
  input  logic                         start,
  input  logic [ppsp_pkg::BYTE_W-1:0]  mag,
  input  logic [ppsp_pkg::BYTE_W-1:0]  low,
  input  logic [ppsp_pkg::BYTE_W:0]    dvs,
  output ppsp_pkg::div_stat_t          stat,
  output logic [ppsp_pkg::NORM_W-1:0]  quot
);

  logic [ppsp_pkg::BYTE_W:0]        rem_r, rem_nxt;
  logic [ppsp_pkg::NORM_W-1:0]      num_r, num_nxt;
  logic [ppsp_pkg::BYTE_W:0]        dvs_r;
  logic [ppsp_pkg::DIV_CNT_W-1:0]   cnt_r;
  logic                             busy_r, done_r;
  logic [ppsp_pkg::BYTE_W+1:0]      trial, diff;
  logic                             ge;

  // shift next numerator bit in, subtract when it fits
  always_comb begin
    trial   = {rem_r, num_r[ppsp_pkg::NORM_W-1]};
    diff    = trial - {1'b0, dvs_r};
    ge      = trial >= {1'b0, dvs_r};
    rem_nxt = ge ? diff[ppsp_pkg::BYTE_W:0] : trial[ppsp_pkg::BYTE_W:0];
    num_nxt = {num_r[ppsp_pkg::NORM_W-2:0], ge};
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= '0;
    end else begin
      done_r <= 1'b0;
      if (start) begin
        busy_r <= 1'b1;
        cnt_r  <= '0;
      end else if (busy_r) begin
        cnt_r <= cnt_r + 1'b1;
        if (cnt_r == ppsp_pkg::DIV_CNT_W'(ppsp_pkg::DIV_STEPS - 1)) begin
          busy_r <= 1'b0;
          done_r <= 1'b1;
        end
      end
    end
  end

  // dividend is mag * 2^16 + low
  always_ff @(posedge clk) begin
    if (start) begin
      rem_r <= {1'b0, mag};
      num_r <= {{(ppsp_pkg::NORM_W-ppsp_pkg::BYTE_W){1'b0}}, low};
      dvs_r <= dvs;
    end else if (busy_r) begin
      rem_r <= rem_nxt;
      num_r <= num_nxt;
    end
  end

  assign stat.busy = busy_r;
  assign stat.done = done_r;
  assign quot      = num_r;

endmodule

// File: hw/rtl/ppsp_parse.sv
// header parser and sample bookkeeping, one byte per step
module ppsp_parse #(
  parameter int MAX_DIM = 4096
) (
  input  logic                         clk,
  input  logic                         rst_n,
  input  logic                         step,
  input  logic [ppsp_pkg::BYTE_W-1:0]  byte_d,
  input  logic                         last_d,
  output ppsp_pkg::res_t               res
);

  localparam int BL_W  = $clog2(MAX_DIM * MAX_DIM * 3 + 1);
  localparam int ACC_W = 17;
  localparam int DW    = ppsp_pkg::DIM_W;

  ppsp_pkg::phase_t          ph_r, ph_nxt;
  logic                      cm_r, cm_nxt;
  logic [DW-1:0]             acc_r, acc_nxt;
  logic [DW-1:0]             w_r, w_nxt;
  logic [DW-1:0]             h_r, h_nxt;
  logic [ppsp_pkg::BYTE_W-1:0] m_r, m_nxt;
  logic [BL_W-1:0]           bl_r, bl_nxt;
  logic [1:0]                ch_r, ch_nxt;

  logic                      is_dig, is_sp;
  logic [ACC_W-1:0]          acc_src, val, lim;
  logic                      num_is_max, over;
  logic                      err_v;
  logic [2:0]                err_c;
  logic [2*DW-1:0]           wh;
  logic [2*DW+1:0]           wh3;

  always_comb begin
    is_dig = (byte_d >= ppsp_pkg::CH_ZERO) && (byte_d <= ppsp_pkg::CH_NINE);
    is_sp  = (byte_d == ppsp_pkg::CH_SPACE) ||
             ((byte_d >= ppsp_pkg::CH_TAB) && (byte_d <= ppsp_pkg::CH_CR));

    // a digit in a skip phase opens a fresh number
    if (ph_r == ppsp_pkg::PH_WIDTH || ph_r == ppsp_pkg::PH_HEIGHT ||
        ph_r == ppsp_pkg::PH_MAX) begin
      acc_src = ACC_W'(acc_r);
    end else begin
      acc_src = '0;
    end
    num_is_max = (ph_r == ppsp_pkg::PH_MAX) || (ph_r == ppsp_pkg::PH_SKIP_M);
    val  = (acc_src << 3) + (acc_src << 1) + ACC_W'(byte_d[3:0]);
    lim  = num_is_max ? ACC_W'(ppsp_pkg::MAXVAL_LIMIT) : ACC_W'(MAX_DIM);
    over = val > lim;

    wh  = {{DW{1'b0}}, w_r} * {{DW{1'b0}}, h_r};
    wh3 = {2'b00, wh} + {1'b0, wh, 1'b0};
  end

  always_comb begin
    ph_nxt  = ph_r;
    cm_nxt  = cm_r;
    acc_nxt = acc_r;
    w_nxt   = w_r;
    h_nxt   = h_r;
    m_nxt   = m_r;
    bl_nxt  = bl_r;
    ch_nxt  = ch_r;
    err_v   = 1'b0;
    err_c   = ppsp_pkg::ERR_BAD_MAGIC;
    res     = '0;

    case (ph_r)
      ppsp_pkg::PH_MAGIC_P: begin
        if (byte_d == ppsp_pkg::CH_P) ph_nxt = ppsp_pkg::PH_MAGIC_6;
        else err_v = 1'b1;
      end
      ppsp_pkg::PH_MAGIC_6: begin
        if (byte_d == ppsp_pkg::CH_SIX) ph_nxt = ppsp_pkg::PH_SKIP_W;
        else err_v = 1'b1;
      end
      ppsp_pkg::PH_SKIP_W, ppsp_pkg::PH_SKIP_H, ppsp_pkg::PH_SKIP_M: begin
        if (cm_r) begin
          if (byte_d == ppsp_pkg::CH_CR || byte_d == ppsp_pkg::CH_LF) cm_nxt = 1'b0;
        end else if (is_sp) begin
          cm_nxt = 1'b0;
        end else if (byte_d == ppsp_pkg::CH_HASH) begin
          cm_nxt = 1'b1;
        end else if (is_dig) begin
          acc_nxt = val[DW-1:0];
          case (ph_r)
            ppsp_pkg::PH_SKIP_W: ph_nxt = ppsp_pkg::PH_WIDTH;
            ppsp_pkg::PH_SKIP_H: ph_nxt = ppsp_pkg::PH_HEIGHT;
            default:             ph_nxt = ppsp_pkg::PH_MAX;
          endcase
          if (over) begin
            err_v = 1'b1;
            err_c = num_is_max ? ppsp_pkg::ERR_BAD_MAX : ppsp_pkg::ERR_TOO_LARGE;
          end
        end else begin
          err_v = 1'b1;
          case (ph_r)
            ppsp_pkg::PH_SKIP_W: err_c = ppsp_pkg::ERR_NO_WIDTH;
            ppsp_pkg::PH_SKIP_H: err_c = ppsp_pkg::ERR_NO_HEIGHT;
            default:             err_c = ppsp_pkg::ERR_NO_MAX;
          endcase
        end
      end
      ppsp_pkg::PH_WIDTH, ppsp_pkg::PH_HEIGHT: begin
        if (is_dig) begin
          acc_nxt = val[DW-1:0];
          if (over) begin
            err_v = 1'b1;
            err_c = ppsp_pkg::ERR_TOO_LARGE;
          end
        end else begin
          if (ph_r == ppsp_pkg::PH_WIDTH) begin
            w_nxt  = acc_r;
            ph_nxt = ppsp_pkg::PH_SKIP_H;
          end else begin
            h_nxt  = acc_r;
            ph_nxt = ppsp_pkg::PH_SKIP_M;
          end
          if (byte_d == ppsp_pkg::CH_HASH) begin
            cm_nxt = 1'b1;
          end else if (!is_sp) begin
            err_v = 1'b1;
            err_c = (ph_r == ppsp_pkg::PH_WIDTH) ? ppsp_pkg::ERR_NO_HEIGHT
                                                 : ppsp_pkg::ERR_NO_MAX;
          end
        end
      end
      ppsp_pkg::PH_MAX: begin
        if (is_dig) begin
          acc_nxt = val[DW-1:0];
          if (over) begin
            err_v = 1'b1;
            err_c = ppsp_pkg::ERR_BAD_MAX;
          end
        end else if (acc_r == '0) begin
          err_v = 1'b1;
          err_c = ppsp_pkg::ERR_BAD_MAX;
        end else if (!is_sp) begin
          err_v = 1'b1;
          err_c = ppsp_pkg::ERR_NO_SEP;
        end else begin
          m_nxt    = acc_r[ppsp_pkg::BYTE_W-1:0];
          bl_nxt   = wh3[BL_W-1:0];
          ch_nxt   = 2'd0;
          res.has  = 1'b1;
          res.kind = ppsp_pkg::KIND_HEADER;
          res.done = (w_r == '0) || (h_r == '0);
          ph_nxt   = res.done ? ppsp_pkg::PH_IDLE : ppsp_pkg::PH_DATA;
        end
      end
      ppsp_pkg::PH_DATA: begin
        bl_nxt   = bl_r - 1'b1;
        res.has  = 1'b1;
        res.kind = ppsp_pkg::KIND_SAMPLE;
        res.raw  = byte_d;
        res.chan = ch_r;
        res.done = (bl_r == BL_W'(1));
        ch_nxt   = (ch_r >= 2'd2) ? 2'd0 : ch_r + 2'd1;
        if (res.done) ph_nxt = ppsp_pkg::PH_IDLE;
      end
      default: begin
      end
    endcase

    if (err_v) begin
      res.has  = 1'b1;
      res.kind = ppsp_pkg::KIND_ERROR;
      res.err  = err_c;
      res.raw  = '0;
      res.chan = '0;
      res.done = 1'b0;
      ph_nxt   = ppsp_pkg::PH_IDLE;
    end

    // buffer end: report what is still missing
    if (last_d && ph_nxt != ppsp_pkg::PH_IDLE) begin
      res.has  = 1'b1;
      res.kind = ppsp_pkg::KIND_ERROR;
      res.raw  = '0;
      res.chan = '0;
      res.done = 1'b0;
      case (ph_nxt)
        ppsp_pkg::PH_DATA:   res.err = ppsp_pkg::ERR_SHORT;
        ppsp_pkg::PH_SKIP_W: res.err = ppsp_pkg::ERR_NO_WIDTH;
        ppsp_pkg::PH_WIDTH,
        ppsp_pkg::PH_SKIP_H: res.err = ppsp_pkg::ERR_NO_HEIGHT;
        ppsp_pkg::PH_HEIGHT,
        ppsp_pkg::PH_SKIP_M: res.err = ppsp_pkg::ERR_NO_MAX;
        ppsp_pkg::PH_MAX:    res.err = (acc_nxt == '0) ? ppsp_pkg::ERR_BAD_MAX
                                                       : ppsp_pkg::ERR_NO_SEP;
        default:             res.err = ppsp_pkg::ERR_BAD_MAGIC;
      endcase
    end

    res.width  = w_nxt;
    res.height = h_nxt;
    res.maxv   = m_nxt;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      ph_r  <= ppsp_pkg::PH_MAGIC_P;
      cm_r  <= 1'b0;
      acc_r <= '0;
      w_r   <= '0;
      h_r   <= '0;
      m_r   <= '0;
      bl_r  <= '0;
      ch_r  <= '0;
    end else if (step) begin
      if (last_d) begin
        ph_r  <= ppsp_pkg::PH_MAGIC_P;
        cm_r  <= 1'b0;
        acc_r <= '0;
        w_r   <= '0;
        h_r   <= '0;
        m_r   <= '0;
        bl_r  <= '0;
        ch_r  <= '0;
      end else begin
        ph_r  <= ph_nxt;
        cm_r  <= cm_nxt;
        acc_r <= acc_nxt;
        w_r   <= w_nxt;
        h_r   <= h_nxt;
        m_r   <= m_nxt;
        bl_r  <= bl_nxt;
        ch_r  <= ch_nxt;
      end
    end
  end

endmodule

// File: hw/rtl/ppm_p6_stream_parser.sv
// top level of the binary ppm (p6) stream parser with q1.15 sample output
//
// channel  direction  handshake            payload
// in       input      in_valid / in_stall  in_byte, in_last
// out      output     out_valid/out_stall  kind, dims, max, raw, norm, channel, error, done
//
// a byte with no result passes the accept and parse steps, one with a result the emit step too
// a sample byte also waits in the divide step while the 16-step serial divider forms
// (2v/max - 1) in q1.15; a sample at or above max saturates and skips the divider
// rst_n is synchronous; it clears the sequencer, parse state and output valid
// the next byte is accepted while a finished result still waits in the output
// register; a stalled output only holds the sequencer at its emit step
module ppm_p6_stream_parser #(
  parameter int MAX_DIM = 4096
) (
  input  logic                               clk,
  input  logic                               rst_n,
  // input channel
  input  logic                               in_valid,
  output logic                               in_stall,
  input  logic [ppsp_pkg::BYTE_W-1:0]        in_byte,
  input  logic                               in_last,
  // result channel
  output logic                               out_valid,
  input  logic                               out_stall,
  output logic [1:0]                         out_kind,
  output logic [ppsp_pkg::DIM_W-1:0]         out_width,
  output logic [ppsp_pkg::DIM_W-1:0]         out_height,
  output logic [ppsp_pkg::BYTE_W-1:0]        out_max_value,
  output logic [ppsp_pkg::BYTE_W-1:0]        out_raw,
  output logic signed [ppsp_pkg::NORM_W-1:0] out_norm,
  output logic [1:0]                         out_channel,
  output logic [2:0]                         out_error,
  output logic                               out_frame_done
);

  ppsp_pkg::seq_t              seq_r, seq_nxt;
  logic [ppsp_pkg::BYTE_W-1:0] byte_r;
  logic                        last_r;
  ppsp_pkg::res_t              res, pend_r;
  logic                        sat_r, neg_r;

  // divider operands
  logic [ppsp_pkg::BYTE_W+1:0] v2, m10, mag10;
  logic                        sat, neg;
  logic [ppsp_pkg::BYTE_W-1:0] div_low;
  logic                        div_start;
  ppsp_pkg::div_stat_t         div_stat;
  logic [ppsp_pkg::NORM_W-1:0] quot;

  // output register
  logic                               ovalid_r;
  logic                               out_load;
  ppsp_pkg::res_t                     ores_r;
  logic signed [ppsp_pkg::NORM_W-1:0] onorm_r, norm_sel;

  logic step;
  logic in_take;

  assign in_take = in_valid && (seq_r == ppsp_pkg::SEQ_IN);
  assign in_stall = (seq_r != ppsp_pkg::SEQ_IN);
  assign step = (seq_r == ppsp_pkg::SEQ_PARSE);

  ppsp_parse #(
    .MAX_DIM (MAX_DIM)
  ) u_parse (
    .clk    (clk),
    .rst_n  (rst_n),
    .step   (step),
    .byte_d (byte_r),
    .last_d (last_r),
    .res    (res)
  );

  // split 2v - max into sign and magnitude; rounding folds into the low word
  always_comb begin
    v2      = {1'b0, res.raw, 1'b0};
    m10     = {2'b00, res.maxv};
    sat     = res.raw >= res.maxv;
    neg     = v2 < m10;
    mag10   = neg ? (m10 - v2) : (v2 - m10);
    div_low = neg ? (res.maxv - 1'b1) : res.maxv;
  end

  assign div_start = step && res.has && (res.kind == ppsp_pkg::KIND_SAMPLE) && !sat;

  ppsp_div u_div (
    .clk   (clk),
    .rst_n (rst_n),
    .start (div_start),
    .mag   (mag10[ppsp_pkg::BYTE_W-1:0]),
    .low   (div_low),
    .dvs   ({res.maxv, 1'b0}),
    .stat  (div_stat),
    .quot  (quot)
  );

  // sequencer: accept, parse, optional divide, emit (only for a byte with a result)
  always_comb begin
    seq_nxt  = seq_r;
    out_load = 1'b0;
    case (seq_r)
      ppsp_pkg::SEQ_IN: begin
        if (in_valid) seq_nxt = ppsp_pkg::SEQ_PARSE;
      end
      ppsp_pkg::SEQ_PARSE: begin
        if (!res.has) seq_nxt = ppsp_pkg::SEQ_IN;
        else if (div_start) seq_nxt = ppsp_pkg::SEQ_DIV;
        else seq_nxt = ppsp_pkg::SEQ_EMIT;
      end
      ppsp_pkg::SEQ_DIV: begin
        if (div_stat.done) seq_nxt = ppsp_pkg::SEQ_EMIT;
      end
      ppsp_pkg::SEQ_EMIT: begin
        if (!ovalid_r || !out_stall) begin
          out_load = 1'b1;
          seq_nxt  = ppsp_pkg::SEQ_IN;
        end
      end
      default: seq_nxt = ppsp_pkg::SEQ_IN;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) seq_r <= ppsp_pkg::SEQ_IN;
    else seq_r <= seq_nxt;
  end

  always_ff @(posedge clk) begin
    if (in_take) begin
      byte_r <= in_byte;
      last_r <= in_last;
    end
    if (step) begin
      pend_r <= res;
      sat_r  <= sat;
      neg_r  <= neg;
    end
  end

  // final q1.15 value
  always_comb begin
    if (pend_r.kind != ppsp_pkg::KIND_SAMPLE) norm_sel = '0;
    else if (sat_r) norm_sel = {1'b0, {(ppsp_pkg::NORM_W-1){1'b1}}};
    else if (neg_r) norm_sel = -$signed(quot);
    else norm_sel = $signed(quot);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      ovalid_r <= 1'b0;
    end else if (out_load) begin
      ovalid_r <= 1'b1;
    end else if (!out_stall) begin
      ovalid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (out_load) begin
      ores_r  <= pend_r;
      onorm_r <= norm_sel;
    end
  end

  assign out_valid      = ovalid_r;
  assign out_kind       = ores_r.kind;
  assign out_width      = ores_r.width;
  assign out_height     = ores_r.height;
  assign out_max_value  = ores_r.maxv;
  assign out_raw        = ores_r.raw;
  assign out_norm       = onorm_r;
  assign out_channel    = ores_r.chan;
  assign out_error      = ores_r.err;
  assign out_frame_done = ores_r.done;

  // an accepted item is parsed on the next cycle
  a_take_parse: assert property (@(posedge clk) disable iff (!rst_n)
    (in_valid && !in_stall) |=> (seq_r == ppsp_pkg::SEQ_PARSE))
    else $error("accepted item not parsed next cycle");

  // the divider is only started when idle
  a_div_idle: assert property (@(posedge clk) disable iff (!rst_n)
    div_start |-> !div_stat.busy)
    else $error("divider restarted while busy");

  // while waiting on the divider it is running or just finished
  a_div_wait: assert property (@(posedge clk) disable iff (!rst_n)
    (seq_r == ppsp_pkg::SEQ_DIV) |-> (div_stat.busy || div_stat.done))
    else $error("sequencer waits on an idle divider");

  // sample results carry no error code, error results no sample
  a_sample_clean: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && out_kind == ppsp_pkg::KIND_SAMPLE) |-> (out_error == ppsp_pkg::ERR_BAD_MAGIC))
    else $error("sample result with error code");

  a_error_clean: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && out_kind == ppsp_pkg::KIND_ERROR) |-> (out_norm == '0 && out_raw == '0))
    else $error("error result with sample payload");

endmodule

// File: verif/tb_top.sv
// self-checking testbench for the binary ppm (p6) stream parser
`timescale 1ns / 1ps

module tb_top;

  localparam int MAX_DIM   = 4096;
  localparam int LONG_HOLD = 400;   // receiver hold-off that backs the block up
  localparam int RAND_ITEMS = 650;

  // kinds of buffers the random part builds
  typedef enum int {
    FL_CLEAN, FL_CUT, FL_NOISE, FL_HUGE, FL_BADMAX, FL_NOSEP, FL_MAGIC
  } flavor_t;

  // one input item plus the pacing that goes with it
  typedef struct {
    logic [ppsp_pkg::BYTE_W-1:0] data;
    logic                        last;
    int                          gap;      // idle cycles before this item
    bit                          drain;    // wait for all results before offering it
    bit                          squeeze;  // start the long receiver hold-off with it
  } byte_item_t;

  // one result as the parser should give it
  typedef struct {
    logic [1:0]                         kind;
    logic [ppsp_pkg::DIM_W-1:0]         width;
    logic [ppsp_pkg::DIM_W-1:0]         height;
    logic [ppsp_pkg::BYTE_W-1:0]        maxv;
    logic [ppsp_pkg::BYTE_W-1:0]        raw;
    logic signed [ppsp_pkg::NORM_W-1:0] norm;
    logic [1:0]                         chan;
    logic [2:0]                         err;
    logic                               done;
  } ppm_result_t;

  logic                                clk = 1'b0;
  logic                                rst_n = 1'b0;
  logic                                in_valid = 1'b0;
  logic                                in_stall;
  logic [ppsp_pkg::BYTE_W-1:0]         in_byte = '0;
  logic                                in_last = 1'b0;
  logic                                out_valid;
  logic                                out_stall = 1'b0;
  logic [1:0]                          out_kind;
  logic [ppsp_pkg::DIM_W-1:0]          out_width;
  logic [ppsp_pkg::DIM_W-1:0]          out_height;
  logic [ppsp_pkg::BYTE_W-1:0]         out_max_value;
  logic [ppsp_pkg::BYTE_W-1:0]         out_raw;
  logic signed [ppsp_pkg::NORM_W-1:0]  out_norm;
  logic [1:0]                          out_channel;
  logic [2:0]                          out_error;
  logic                                out_frame_done;

  ppm_p6_stream_parser #(.MAX_DIM(MAX_DIM)) dut (
    .clk            (clk),
    .rst_n          (rst_n),
    .in_valid       (in_valid),
    .in_stall       (in_stall),
    .in_byte        (in_byte),
    .in_last        (in_last),
    .out_valid      (out_valid),
    .out_stall      (out_stall),
    .out_kind       (out_kind),
    .out_width      (out_width),
    .out_height     (out_height),
    .out_max_value  (out_max_value),
    .out_raw        (out_raw),
    .out_norm       (out_norm),
    .out_channel    (out_channel),
    .out_error      (out_error),
    .out_frame_done (out_frame_done)
  );

  always begin
    #1 clk = 1'b1;
    #1 clk = 1'b0;
  end

  // ---------------------------------------------------------------------------
  // parser shadow: follows the header state machine byte by byte
  // ---------------------------------------------------------------------------
  ppsp_pkg::phase_t phase;
  bit               cmt_open;
  int unsigned      num_acc;
  int unsigned      img_w;
  int unsigned      img_h;
  int unsigned      max_v;
  int unsigned      samples_left;
  int               chan_idx;

  ppm_result_t     expected_q[$];
  byte_item_t      byte_queue[$];
  logic [7:0]      frame_bytes[$];

  int fail_cnt = 0;
  int bytes_in = 0;
  int n_headers = 0;
  int n_samples = 0;
  int n_errors = 0;
  int n_buffers = 0;
  int random_items = 0;

  function automatic bit is_ws(logic [7:0] c);
    return c == ppsp_pkg::CH_SPACE || (c >= ppsp_pkg::CH_TAB && c <= ppsp_pkg::CH_CR);
  endfunction

  function automatic bit is_num(logic [7:0] c);
    return c >= ppsp_pkg::CH_ZERO && c <= ppsp_pkg::CH_NINE;
  endfunction

  function automatic void restart_parser();
    phase = ppsp_pkg::PH_MAGIC_P;
    cmt_open = 1'b0;
    num_acc = 0;
    img_w = 0;
    img_h = 0;
    max_v = 0;
    samples_left = 0;
    chan_idx = 0;
  endfunction

  // q1.15 of 2v/m - 1, round half up, saturated
  function automatic int scale_sample(int v, int m);
    longint num, den, q;
    num = (longint'(2 * v) - longint'(m)) * 65536 + longint'(m);
    den = 2 * longint'(m);
    if (num >= 0) q = num / den;
    else q = -((-num + den - 1) / den);
    if (q > 32767) q = 32767;
    if (q < -32768) q = -32768;
    return int'(q);
  endfunction

  function automatic ppm_result_t make_result(logic [1:0] kind, int raw, int norm,
                                              int chan, int err, bit done);
    ppm_result_t r;
    r.kind   = kind;
    r.width  = img_w[ppsp_pkg::DIM_W-1:0];
    r.height = img_h[ppsp_pkg::DIM_W-1:0];
    r.maxv   = max_v[ppsp_pkg::BYTE_W-1:0];
    r.raw    = raw[ppsp_pkg::BYTE_W-1:0];
    r.norm   = norm[ppsp_pkg::NORM_W-1:0];
    r.chan   = chan[1:0];
    r.err    = err[2:0];
    r.done   = done;
    return r;
  endfunction

  // next digit of the number in progress; returns an error code or -1
  function automatic int push_digit(logic [7:0] c);
    int unsigned lim;
    lim = (phase == ppsp_pkg::PH_MAX) ? ppsp_pkg::MAXVAL_LIMIT : MAX_DIM;
    num_acc = num_acc * 10 + (c - ppsp_pkg::CH_ZERO);
    if (num_acc > lim) begin
      return (phase == ppsp_pkg::PH_MAX) ? int'(ppsp_pkg::ERR_BAD_MAX)
                                         : int'(ppsp_pkg::ERR_TOO_LARGE);
    end
    return -1;
  endfunction

  // byte where whitespace, a comment or the start of a number may come
  function automatic int skip_hdr(logic [7:0] c);
    if (cmt_open) begin
      if (c == ppsp_pkg::CH_CR || c == ppsp_pkg::CH_LF) cmt_open = 1'b0;
      return -1;
    end
    if (is_ws(c)) return -1;
    if (c == ppsp_pkg::CH_HASH) begin
      cmt_open = 1'b1;
      return -1;
    end
    if (is_num(c)) begin
      phase = ppsp_pkg::phase_t'(phase + 1);
      num_acc = 0;
      return push_digit(c);
    end
    // anything else: the number that should come is missing
    case (phase)
      ppsp_pkg::PH_SKIP_W: return ppsp_pkg::ERR_NO_WIDTH;
      ppsp_pkg::PH_SKIP_H: return ppsp_pkg::ERR_NO_HEIGHT;
      default:             return ppsp_pkg::ERR_NO_MAX;
    endcase
  endfunction

  // one accepted item: advance the shadow and queue what it should give
  function automatic void parse_byte(logic [7:0] c, logic lst);
    int err;
    bit has;
    int code;
    ppm_result_t r;
    err = -1;
    has = 1'b0;
    case (phase)
      ppsp_pkg::PH_MAGIC_P: begin
        if (c == ppsp_pkg::CH_P) phase = ppsp_pkg::PH_MAGIC_6;
        else err = ppsp_pkg::ERR_BAD_MAGIC;
      end
      ppsp_pkg::PH_MAGIC_6: begin
        if (c == ppsp_pkg::CH_SIX) phase = ppsp_pkg::PH_SKIP_W;
        else err = ppsp_pkg::ERR_BAD_MAGIC;
      end
      ppsp_pkg::PH_SKIP_W, ppsp_pkg::PH_SKIP_H, ppsp_pkg::PH_SKIP_M: err = skip_hdr(c);
      ppsp_pkg::PH_WIDTH, ppsp_pkg::PH_HEIGHT: begin
        if (is_num(c)) begin
          err = push_digit(c);
        end else begin
          // the digit run ends here; this byte is then handled as a separator
          if (phase == ppsp_pkg::PH_WIDTH) img_w = num_acc;
          else img_h = num_acc;
          phase = ppsp_pkg::phase_t'(phase + 1);
          err = skip_hdr(c);
        end
      end
      ppsp_pkg::PH_MAX: begin
        if (is_num(c)) begin
          err = push_digit(c);
        end else if (num_acc == 0) begin
          err = ppsp_pkg::ERR_BAD_MAX;
        end else if (!is_ws(c)) begin
          err = ppsp_pkg::ERR_NO_SEP;
        end else begin
          max_v = num_acc;
          samples_left = img_w * img_h * 3;
          chan_idx = 0;
          r = make_result(ppsp_pkg::KIND_HEADER, 0, 0, 0, 0, samples_left == 0);
          has = 1'b1;
          phase = (samples_left == 0) ? ppsp_pkg::PH_IDLE : ppsp_pkg::PH_DATA;
        end
      end
      ppsp_pkg::PH_DATA: begin
        samples_left--;
        r = make_result(ppsp_pkg::KIND_SAMPLE, c, scale_sample(c, max_v), chan_idx, 0,
                        samples_left == 0);
        has = 1'b1;
        chan_idx = (chan_idx >= 2) ? 0 : chan_idx + 1;
        if (samples_left == 0) phase = ppsp_pkg::PH_IDLE;
      end
      default: ;
    endcase

    if (err >= 0) begin
      r = make_result(ppsp_pkg::KIND_ERROR, 0, 0, 0, err, 1'b0);
      has = 1'b1;
      phase = ppsp_pkg::PH_IDLE;
    end

    if (lst) begin
      // buffer ends early: the first missing piece is reported
      if (phase == ppsp_pkg::PH_DATA) begin
        r = make_result(ppsp_pkg::KIND_ERROR, 0, 0, 0, ppsp_pkg::ERR_SHORT, 1'b0);
        has = 1'b1;
      end else if (phase < ppsp_pkg::PH_DATA) begin
        case (phase)
          ppsp_pkg::PH_MAGIC_P, ppsp_pkg::PH_MAGIC_6: code = ppsp_pkg::ERR_BAD_MAGIC;
          ppsp_pkg::PH_SKIP_W:                        code = ppsp_pkg::ERR_NO_WIDTH;
          ppsp_pkg::PH_WIDTH, ppsp_pkg::PH_SKIP_H:    code = ppsp_pkg::ERR_NO_HEIGHT;
          ppsp_pkg::PH_HEIGHT, ppsp_pkg::PH_SKIP_M:   code = ppsp_pkg::ERR_NO_MAX;
          default: code = (num_acc == 0) ? ppsp_pkg::ERR_BAD_MAX : ppsp_pkg::ERR_NO_SEP;
        endcase
        r = make_result(ppsp_pkg::KIND_ERROR, 0, 0, 0, code, 1'b0);
        has = 1'b1;
      end
      restart_parser();
    end

    if (has) expected_q.push_back(r);
  endfunction

  // ---------------------------------------------------------------------------
  // input side: accept detection at the rising edge, driving at the falling edge
  // ---------------------------------------------------------------------------
  logic byte_taken = 1'b0;
  int   hold_ask = 0;
  int   wait_cnt = 0;

  always @(posedge clk) begin
    byte_taken <= rst_n && in_valid && !in_stall;
    if (rst_n && in_valid && !in_stall) begin
      parse_byte(in_byte, in_last);
      bytes_in++;
    end
  end

  always @(negedge clk) begin
    byte_item_t cur;
    // slot is free when nothing is offered or the offered item just went in
    if (rst_n && (!in_valid || byte_taken)) begin
      if (byte_queue.size() == 0) begin
        in_valid <= 1'b0;
      end else if (wait_cnt > 0) begin
        in_valid <= 1'b0;
        wait_cnt--;
      end else if (byte_queue[0].drain && expected_q.size() != 0) begin
        // hold the next buffer until the parser has emptied out
        in_valid <= 1'b0;
      end else begin
        cur = byte_queue.pop_front();
        in_byte  <= cur.data;
        in_last  <= cur.last;
        in_valid <= 1'b1;
        if (cur.squeeze) hold_ask <= hold_ask + 1;
        if (byte_queue.size() != 0) wait_cnt = byte_queue[0].gap;
      end
    end
  end

  // ---------------------------------------------------------------------------
  // result side: random stall per item, one long hold-off on request
  // ---------------------------------------------------------------------------
  logic result_taken = 1'b0;
  int   hold_seen = 0;
  int   stall_left = 0;
  int   results_seen = 0;

  always @(negedge clk) begin
    if (result_taken) begin
      // calm stretches with no stall at all, else a fresh draw per item
      if ((results_seen / 32) % 3 == 1) stall_left = 0;
      else stall_left = $urandom_range(0, 15);
    end
    if (hold_ask != hold_seen) begin
      hold_seen = hold_ask;
      stall_left = LONG_HOLD;
    end
    if (stall_left > 0) begin
      out_stall <= 1'b1;
      stall_left--;
    end else begin
      out_stall <= 1'b0;
    end
  end

  function automatic void check_field(string name, logic signed [31:0] want,
                                      logic signed [31:0] got);
    if (got !== want) begin
      $error("%s: expected %0d, got %0d", name, want, got);
      fail_cnt++;
    end
  endfunction

  always @(posedge clk) begin
    ppm_result_t want;
    result_taken <= rst_n && out_valid && !out_stall;
    if (rst_n && out_valid && !out_stall) begin
      results_seen++;
      case (out_kind)
        ppsp_pkg::KIND_SAMPLE: n_samples++;
        ppsp_pkg::KIND_HEADER: n_headers++;
        default:               n_errors++;
      endcase
      if (expected_q.size() == 0) begin
        $error("out_kind: no result expected, got %0d", out_kind);
        fail_cnt++;
      end else begin
        want = expected_q.pop_front();
        check_field("out_kind", want.kind, out_kind);
        check_field("out_width", want.width, out_width);
        check_field("out_height", want.height, out_height);
        check_field("out_max_value", want.maxv, out_max_value);
        check_field("out_raw", want.raw, out_raw);
        check_field("out_norm", want.norm, out_norm);
        check_field("out_channel", want.chan, out_channel);
        check_field("out_error", want.err, out_error);
        check_field("out_frame_done", want.done, out_frame_done);
      end
    end
  end

  // ---------------------------------------------------------------------------
  // buffer building
  // ---------------------------------------------------------------------------
  task automatic add_text(input string s);
    for (int i = 0; i < s.len(); i++) frame_bytes.push_back(s[i]);
  endtask

  // decimal number, sometimes with a leading zero
  task automatic add_num(input int n);
    if ($urandom_range(0, 5) == 0) add_text("0");
    add_text($sformatf("%0d", n));
  endtask

  // whitespace run mixed with comment lines
  task automatic add_filler();
    int toks;
    int len;
    logic [7:0] b;
    toks = $urandom_range(1, 3);
    for (int t = 0; t < toks; t++) begin
      if ($urandom_range(0, 5) == 0) begin
        frame_bytes.push_back(ppsp_pkg::CH_HASH);
        len = $urandom_range(0, 4);
        for (int k = 0; k < len; k++) begin
          do b = 8'($urandom_range(0, 255));
          while (b == ppsp_pkg::CH_CR || b == ppsp_pkg::CH_LF);
          frame_bytes.push_back(b);
        end
        frame_bytes.push_back($urandom_range(0, 1) ? ppsp_pkg::CH_CR : ppsp_pkg::CH_LF);
      end else if ($urandom_range(0, 1)) begin
        frame_bytes.push_back(ppsp_pkg::CH_SPACE);
      end else begin
        frame_bytes.push_back(8'($urandom_range(ppsp_pkg::CH_TAB, ppsp_pkg::CH_CR)));
      end
    end
  endtask

  // move the built buffer into the item queue, last flag on its final byte
  task automatic ship_frame(input bit hurry, input bit drain, input bit squeeze);
    byte_item_t it;
    foreach (frame_bytes[i]) begin
      it.data    = frame_bytes[i];
      it.last    = (i == frame_bytes.size() - 1);
      it.gap     = hurry ? 0 : $urandom_range(0, 15);
      it.drain   = drain && (i == 0);
      it.squeeze = squeeze && (i == 0);
      byte_queue.push_back(it);
    end
    frame_bytes.delete();
    n_buffers++;
  endtask

  task automatic gen_buffer(input flavor_t fl, input bit squeeze, input bit hurry,
                            input bit drain);
    int wd, ht, mx, hdr_len, n_data, cut, pos, extra;
    logic [7:0] b;
    frame_bytes.delete();
    wd = $urandom_range(0, 3);
    ht = $urandom_range(0, 3);
    if ($urandom_range(0, 9) == 0) begin
      // one side at the size limit, the other empty
      if ($urandom_range(0, 1)) begin
        wd = MAX_DIM;
        ht = 0;
      end else begin
        wd = 0;
        ht = MAX_DIM;
      end
    end
    if (squeeze) begin
      wd = 3;
      ht = 3;
    end
    case ($urandom_range(0, 3))
      0:       mx = 1;
      1:       mx = 255;
      default: mx = $urandom_range(1, 255);
    endcase
    if (fl == FL_HUGE) begin
      if ($urandom_range(0, 1)) wd = $urandom_range(MAX_DIM + 1, 99999);
      else ht = $urandom_range(MAX_DIM + 1, 99999);
    end
    if (fl == FL_BADMAX) mx = $urandom_range(0, 1) ? 0 : $urandom_range(256, 999);

    // magic
    if (fl == FL_MAGIC) begin
      if ($urandom_range(0, 1)) begin
        do b = 8'($urandom_range(0, 255)); while (b == ppsp_pkg::CH_P);
        frame_bytes.push_back(b);
      end else begin
        frame_bytes.push_back(ppsp_pkg::CH_P);
        do b = 8'($urandom_range(0, 255)); while (b == ppsp_pkg::CH_SIX);
        frame_bytes.push_back(b);
      end
    end else begin
      add_text("P6");
    end

    add_filler();
    add_num(wd);
    add_filler();
    add_num(ht);
    add_filler();
    add_num(mx);

    // the single separator after the maximum, or something that is not one
    if (fl == FL_NOSEP) begin
      do b = 8'($urandom_range(0, 255)); while (is_ws(b) || is_num(b));
      frame_bytes.push_back(b);
    end else if ($urandom_range(0, 1)) begin
      frame_bytes.push_back(ppsp_pkg::CH_SPACE);
    end else begin
      frame_bytes.push_back(8'($urandom_range(ppsp_pkg::CH_TAB, ppsp_pkg::CH_CR)));
    end
    hdr_len = frame_bytes.size();

    n_data = (fl == FL_CLEAN || fl == FL_CUT || fl == FL_NOISE) ? wd * ht * 3 : 0;
    for (int i = 0; i < n_data; i++) begin
      case ($urandom_range(0, 7))
        0:       b = 8'h00;
        1:       b = 8'hFF;
        2:       b = 8'(mx);
        3:       b = 8'(mx - 1);
        default: b = 8'($urandom_range(0, 255));
      endcase
      frame_bytes.push_back(b);
    end
    random_items += frame_bytes.size();

    // surplus after a complete frame is skipped until the last flag
    if (fl == FL_CLEAN && $urandom_range(0, 3) == 0) begin
      extra = $urandom_range(1, 3);
      for (int i = 0; i < extra; i++) frame_bytes.push_back(8'($urandom_range(0, 255)));
    end
    if (fl == FL_NOISE) begin
      pos = $urandom_range(0, hdr_len - 1);
      frame_bytes[pos] = 8'($urandom_range(0, 255));
    end
    if (fl == FL_CUT) begin
      cut = $urandom_range(1, frame_bytes.size());
      while (frame_bytes.size() > cut) void'(frame_bytes.pop_back());
    end
    ship_frame(hurry, drain, squeeze);
  endtask

  // ---------------------------------------------------------------------------
  // stimulus and end of run
  // ---------------------------------------------------------------------------
  initial begin
    flavor_t fl;
    int nb;
    restart_parser();

    // full frame at max 255 with the sample extremes
    add_text("P6\n1 1 255\n");
    frame_bytes.push_back(8'h00);
    frame_bytes.push_back(8'hFF);
    frame_bytes.push_back(8'h80);
    ship_frame(1'b0, 1'b0, 1'b0);
    // comment right after the magic, zero width, smallest maximum
    add_text("P6#\n0 1 1 ");
    ship_frame(1'b0, 1'b1, 1'b0);
    // single byte buffer with a wrong magic
    add_text("Q");
    ship_frame(1'b0, 1'b0, 1'b0);

    // random buffers: every other one clean, the rest cycle through the damage kinds
    nb = 0;
    while (random_items < RAND_ITEMS) begin
      fl = (nb % 2 == 0) ? FL_CLEAN : flavor_t'(1 + (nb / 2) % 6);
      gen_buffer(fl, nb == 10, nb == 10 || $urandom_range(0, 2) == 0, nb % 9 == 4);
      nb++;
    end

    repeat (11) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    while (byte_queue.size() != 0 || in_valid) @(posedge clk);
    while (expected_q.size() != 0) @(posedge clk);
    // room for any stray result after the last expected one
    repeat (60) @(posedge clk);

    $display("%0d buffers, %0d bytes in; headers %0d, samples %0d, errors %0d",
             n_buffers, bytes_in, n_headers, n_samples, n_errors);
    $display("mismatches: %0d", fail_cnt);
    if (fail_cnt == 0) begin
      $display("TB_OK");
    end else begin
      $display("TB_ERROR");
    end
    $finish;
  end

  // watchdog
  initial begin
    #1000000;
    $display("TB_ERROR");
    $finish;
  end

endmodule
